>>> rtl/core/cab_pkg.sv
// ----------------------------------------------------------------------------
// Chromatic aberration row package
// Shared constants, codes and per-channel helper functions for the
// chromatic aberration row block and its memories.
// ----------------------------------------------------------------------------
package cab_pkg;

   // Default number of row entries in the pixel store.
   localparam int unsigned ROW_DEPTH_DEF = 1024;

   // Width of the signed column arithmetic: column plus or minus shift,
   // compared against a row width of up to 2047.
   localparam int unsigned XW = 15;

   // Field widths of the transactions.
   localparam int unsigned COL_W   = 10;
   localparam int unsigned PIXEL_W = 32;
   localparam int unsigned CSR_W   = 11;

   // Request operation codes.
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_PROC = 1'b1;

   // Configuration register indexes.
   localparam logic CSR_SHIFT = 1'b0;
   localparam logic CSR_WIDTH = 1'b1;

   // Reduce a column into the store depth by conditional subtraction of
   // scaled copies of the depth (the depth is a constant, so most steps fold).
   function automatic logic [COL_W-1:0] col_mod(input logic [COL_W-1:0] col,
                                                input int unsigned depth);
      logic [COL_W-1:0] rem;
      int unsigned      step;
      rem = col;
      for (int k = COL_W - 1; k >= 0; k--) begin
         step = depth << k;
         if (step <= int'(rem)) begin
            rem = rem - COL_W'(step);
         end
      end
      return rem;
   endfunction

   // Clamp a signed column into 0 .. width-1.
   function automatic logic [XW-1:0] clamp_col(input logic signed [XW-1:0] pos,
                                                input logic [XW-1:0] width);
      logic [XW-1:0] res;
      if (pos < 0) begin
         res = '0;
      end else if (pos >= $signed(width)) begin
         res = width - XW'(1);
      end else begin
         res = pos;
      end
      return res;
   endfunction

   // Move channel c toward s by floor((s - c) * cov / 256).
   function automatic logic [7:0] ease_channel(input logic [7:0] c,
                                               input logic [7:0] s,
                                               input logic [7:0] cov);
      logic signed [8:0]  diff;
      logic signed [17:0] prod;
      logic signed [17:0] scaled;
      diff   = $signed({1'b0, s}) - $signed({1'b0, c});
      prod   = diff * $signed({1'b0, cov});
      scaled = prod >>> 8;
      return c + scaled[7:0];
   endfunction

endpackage

>>> rtl/core/cab_ram.sv
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port with a registered read that holds its
// data while the read enable is low.
// ----------------------------------------------------------------------------
module cab_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/chromatic_aberration_row.sv
// ----------------------------------------------------------------------------
// Chromatic aberration row
// Stores one row of RGBA pixels and produces color-fringed pixels from it.
//
// Request channel (req_*): a load transaction writes req_source_pixel at
// req_column and gives no response. A process transaction reads red from
// column x - shift, green and alpha from x and blue from x + shift (sides
// clamped to the row width) and gives one response on rsp_*, either the
// replaced pixel or a coverage-weighted blend toward it.
// Configuration (csr_*): csr_index 0 is the signed shift, 1 the row width;
// writes take effect at the next clock edge; the user must make them only
// while idle; the block does not enforce it. A process transaction passes
// the read stage and the response register before rsp_valid, one per cycle
// unless the receiver stalls. Each process request reads each of three row
// store copies, written together. A load followed directly by a process of
// the same entry sees the new data. When the receiver stalls, the response
// register and one read stage fill and req_ready drops until rsp_ready
// returns. Reset clears the valid flags and the registers (shift 0, width
// 1024); the row store is not cleared and holds nothing defined until loaded.
// ----------------------------------------------------------------------------
module chromatic_aberration_row
   import cab_pkg::*;
#(
   parameter int unsigned MAX_ROW = ROW_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   // Request channel
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_op,
   input  logic [COL_W-1:0]   req_column,
   input  logic [PIXEL_W-1:0] req_source_pixel,
   input  logic               req_use_mask,
   input  logic [7:0]         req_coverage,
   // Response channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [PIXEL_W-1:0] rsp_result_pixel,
   // Configuration port
   input  logic               csr_wr_en,
   input  logic               csr_index,
   input  logic [CSR_W-1:0]   csr_wr_data
);

   localparam int unsigned AW = $clog2(MAX_ROW);

   // Configuration registers.
   logic signed [CSR_W-1:0] shift_ff;
   logic [CSR_W-1:0]        width_ff;

   // Pipeline control and payload.
   logic               s1_valid_ff, s1_valid_in;
   logic               s1_use_mask_ff;
   logic [7:0]         s1_coverage_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [PIXEL_W-1:0] rsp_pixel_ff, rsp_pixel_in;

   // Request-side signals.
   logic                 req_fire, proc_fire, load_fire, out_load;
   logic [AW-1:0]        center_addr, red_addr, blue_addr;
   logic [XW-1:0]        width_eff, red_clamped, blue_clamped;
   logic signed [XW-1:0] col_ext, shift_ext, red_pos, blue_pos;

   // Read data from the three row copies.
   logic [PIXEL_W-1:0] pix_red, pix_mid, pix_blue, sample;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= '0;
         width_ff <= CSR_W'(1024);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SHIFT: shift_ff <= csr_wr_data;
            CSR_WIDTH: width_ff <= csr_wr_data;
         endcase
      end
   end

   // Handshake: the read stage may take a new transaction when it is empty
   // or when its result moves into the response register this cycle.
   assign out_load  = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || out_load;
   assign req_fire  = req_valid && req_ready;
   assign proc_fire = req_fire && (req_op == OP_PROC);
   assign load_fire = req_fire && (req_op == OP_LOAD);

   // Effective clamp width: zero acts as one, anything above the depth as the depth.
   always_comb begin
      if (width_ff == '0) begin
         width_eff = XW'(1);
      end else if (XW'(width_ff) > XW'(MAX_ROW)) begin
         width_eff = XW'(MAX_ROW);
      end else begin
         width_eff = XW'(width_ff);
      end
   end

   // Side columns, clamped into the row.
   assign col_ext      = $signed(XW'(req_column));
   assign shift_ext    = {{(XW - CSR_W){shift_ff[CSR_W-1]}}, shift_ff};
   assign red_pos      = col_ext - shift_ext;
   assign blue_pos     = col_ext + shift_ext;
   assign red_clamped  = clamp_col(red_pos, width_eff);
   assign blue_clamped = clamp_col(blue_pos, width_eff);
   assign red_addr     = AW'(red_clamped);
   assign blue_addr    = AW'(blue_clamped);
   assign center_addr  = AW'(col_mod(req_column, MAX_ROW));

   // Three copies of the row store, written together, each read once.
   cab_ram #(.WIDTH(PIXEL_W), .DEPTH(MAX_ROW)) u_ram_red (
      .clock   (clock),
      .wr_en   (load_fire),
      .wr_addr (center_addr),
      .wr_data (req_source_pixel),
      .rd_en   (proc_fire),
      .rd_addr (red_addr),
      .rd_data (pix_red)
   );

   cab_ram #(.WIDTH(PIXEL_W), .DEPTH(MAX_ROW)) u_ram_mid (
      .clock   (clock),
      .wr_en   (load_fire),
      .wr_addr (center_addr),
      .wr_data (req_source_pixel),
      .rd_en   (proc_fire),
      .rd_addr (center_addr),
      .rd_data (pix_mid)
   );

   cab_ram #(.WIDTH(PIXEL_W), .DEPTH(MAX_ROW)) u_ram_blue (
      .clock   (clock),
      .wr_en   (load_fire),
      .wr_addr (center_addr),
      .wr_data (req_source_pixel),
      .rd_en   (proc_fire),
      .rd_addr (blue_addr),
      .rd_data (pix_blue)
   );

   // Read stage valid.
   always_comb begin
      if (proc_fire) begin
         s1_valid_in = 1'b1;
      end else if (out_load) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // Mode fields travel alongside the memory read.
   always_ff @(posedge clock) begin
      if (proc_fire) begin
         s1_use_mask_ff <= req_use_mask;
         s1_coverage_ff <= req_coverage;
      end
   end

   // Assemble the shifted sample and blend the center pixel toward it.
   assign sample = {pix_mid[31:24], pix_blue[23:16], pix_mid[15:8], pix_red[7:0]};

   always_comb begin
      if (!s1_use_mask_ff) begin
         rsp_pixel_in = sample;
      end else if (s1_coverage_ff == '0) begin
         rsp_pixel_in = pix_mid;
      end else begin
         rsp_pixel_in = {pix_mid[31:24],
                         ease_channel(pix_mid[23:16], sample[23:16], s1_coverage_ff),
                         ease_channel(pix_mid[15:8],  sample[15:8],  s1_coverage_ff),
                         ease_channel(pix_mid[7:0],   sample[7:0],   s1_coverage_ff)};
      end
   end

   // Response register.
   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_pixel_ff <= rsp_pixel_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_pixel = rsp_pixel_ff;

`ifndef SYNTHESIS
   // A full pipeline facing a stalled receiver must refuse new requests.
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("request accepted while pipeline is full and stalled");

   // Every accepted process transaction occupies the read stage next cycle.
   a_proc_enters: assert property (@(posedge clock) disable iff (reset)
      proc_fire |=> s1_valid_ff)
      else $error("process transaction lost before the read stage");

   // A load never produces a response.
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      load_fire |=> !s1_valid_ff)
      else $error("load transaction produced a read stage entry");

   // Side reads stay inside the effective row.
   a_side_in_row: assert property (@(posedge clock) disable iff (reset)
      proc_fire |-> ((red_clamped < width_eff) && (blue_clamped < width_eff)))
      else $error("side column outside the row");

   // A response appears only from a filled read stage.
   a_rsp_from_s1: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff))
      else $error("response raised without read stage data");
`endif

endmodule
